// ===== design/qa_pkg.sv =====
package qa_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int PROD_W        = 64;
    localparam int SUM_W         = 67;
    localparam int Q_DEPTH       = 2;

    typedef logic signed [31:0] t_word;

    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        MD_ADD   = 3'd0,
        MD_SUB   = 3'd1,
        MD_SMUL  = 3'd2,
        MD_HAM   = 3'd3,
        MD_CONJ  = 3'd4,
        MD_INV   = 3'd5,
        MD_SCALE = 3'd6,
        MD_UNSC  = 3'd7
    } t_mode;

    // Negated terms of the Hamilton product, one row per result lane, bit = term
    localparam logic [3:0][3:0] HAM_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

    typedef struct packed {
        t_mode       mode;
        t_word [3:0] a;
        t_word [3:0] b;
        logic        a_zero;
        logic  [3:0] b_zero;
    } t_req;

    typedef struct packed {
        t_word [3:0] r;
        logic        sat;
        logic        dz;
    } t_res;

endpackage

// ===== design/qa_front.sv =====
module qa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [2:0]    i_mode,
    input  qa_pkg::t_word i_a_w,
    input  qa_pkg::t_word i_a_x,
    input  qa_pkg::t_word i_a_y,
    input  qa_pkg::t_word i_a_z,
    input  qa_pkg::t_word i_b_w,
    input  qa_pkg::t_word i_b_x,
    input  qa_pkg::t_word i_b_y,
    input  qa_pkg::t_word i_b_z,
    input  logic          i_full,
    output logic          o_push,
    output qa_pkg::t_req  o_req
);
    import qa_pkg::*;

    logic r_valid;
    t_req r_req;
    t_req n_req;
    logic load;

    assign o_push  = r_valid && !i_full;
    assign o_stall = r_valid && i_full;
    assign load    = i_valid && !o_stall;
    assign o_req   = r_req;

    // classify: decode opcode, flag zero operands
    always_comb begin
        n_req.mode      = t_mode'(i_mode);
        n_req.a         = {i_a_z, i_a_y, i_a_x, i_a_w};
        n_req.b         = {i_b_z, i_b_y, i_b_x, i_b_w};
        n_req.a_zero    = (i_a_w == '0) && (i_a_x == '0) && (i_a_y == '0) && (i_a_z == '0);
        n_req.b_zero[0] = (i_b_w == '0);
        n_req.b_zero[1] = (i_b_x == '0);
        n_req.b_zero[2] = (i_b_y == '0);
        n_req.b_zero[3] = (i_b_z == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_req <= n_req;
        end
    end

endmodule

// ===== design/qa_fifo.sv =====
module qa_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  qa_pkg::t_req i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output qa_pkg::t_req o_data
);
    import qa_pkg::*;

    localparam int AW = $clog2(Q_DEPTH);

    t_req           r_mem [Q_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== design/qa_back.sv =====
module qa_back #(
    parameter int FRAC_BITS = qa_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_head_valid,
    input  qa_pkg::t_req i_head,
    output logic         o_pop,
    output logic         o_valid,
    input  logic         i_stall,
    output qa_pkg::t_res o_res
);
    import qa_pkg::*;

    localparam int NUM_W = 33 + FRAC_BITS;
    localparam int NRM_W = 65 - FRAC_BITS;
    localparam int DW    = ((NUM_W > NRM_W) ? NUM_W : NRM_W) + 2;
    localparam int QW    = 32;
    localparam logic signed [SUM_W-1:0] HALF =
        {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    typedef struct packed {
        logic            is_div;
        logic            neg;
        logic            ovf;
        logic            sat;
        t_word           res;
        logic [DW-1:0]   r;
        logic [DW-1:0]   d;
        logic [QW-1:0]   nlo;
        logic [QW-1:0]   q;
    } t_dvl;

    function automatic t_dvl dv_step(t_dvl s);
        t_dvl          o;
        logic [DW-1:0] rr;
        logic          ge;
        o     = s;
        rr    = {s.r[DW-2:0], s.nlo[QW-1]};
        ge    = (rr >= s.d);
        o.r   = ge ? rr - s.d : rr;
        o.nlo = s.nlo << 1;
        o.q   = {s.q[QW-2:0], ge};
        return o;
    endfunction

    logic en;

    logic                      r1_valid, r2_valid, r3_valid, r4_valid;
    t_req                      r1_req, r2_req, r3_req;
    logic                      r4_dz;
    logic signed [PROD_W-1:0]  r1_prod [4][4];
    logic signed [PROD_W-1:0]  n_prod  [4][4];
    logic                      r1_neg  [4][4];
    logic                      n_neg   [4][4];
    logic signed [SUM_W-1:0]   r2_pair [4][2];
    logic signed [SUM_W-1:0]   n_pair  [4][2];
    logic signed [SUM_W-1:0]   r3_dot  [4];
    logic signed [SUM_W-1:0]   n_dot   [4];
    t_dvl                      r4_lane [4];
    t_dvl                      n_lane  [4];
    t_dvl                      n_dv0   [4];
    t_dvl                      r_dv    [QW+1][4];
    logic                      r_dv_valid [QW+1];
    logic                      r_dv_dz    [QW+1];
    t_res                      r_out;
    t_res                      n_out;
    logic                      r_out_valid;

    assign en      = !r_out_valid || !i_stall;
    assign o_pop   = en && i_head_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // operand routing to the sixteen multipliers
    always_comb begin
        t_word opa;
        t_word opb;
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 4; i++) begin
                opa = '0;
                opb = '0;
                n_neg[j][i] = 1'b0;
                unique case (i_head.mode)
                    MD_HAM: begin
                        opa = i_head.a[i];
                        opb = i_head.b[i ^ j];
                        n_neg[j][i] = HAM_NEG[j][i];
                    end
                    MD_SMUL: begin
                        if (i == 0) begin
                            opa = i_head.a[j];
                            opb = i_head.b[0];
                        end
                    end
                    MD_SCALE: begin
                        if (i == 0) begin
                            opa = i_head.a[j];
                            opb = i_head.b[j];
                        end
                    end
                    MD_INV: begin
                        if (j == 0) begin
                            opa = i_head.a[i];
                            opb = i_head.a[i];
                        end
                    end
                    default: begin
                    end
                endcase
                n_prod[j][i] = opa * opb;
            end
        end
    end

    // signed pair sums
    always_comb begin
        logic signed [SUM_W-1:0] e0;
        logic signed [SUM_W-1:0] e1;
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 2; k++) begin
                e0 = SUM_W'(r1_prod[j][2*k]);
                e1 = SUM_W'(r1_prod[j][2*k+1]);
                if (r1_neg[j][2*k]) begin
                    e0 = -e0;
                end
                if (r1_neg[j][2*k+1]) begin
                    e1 = -e1;
                end
                n_pair[j][k] = e0 + e1;
            end
        end
    end

    // round to nearest, ties up
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_dot[j] = (r2_pair[j][0] + r2_pair[j][1] + HALF) >>> FRAC_BITS;
        end
    end

    // per-lane result select, clip, divider setup
    always_comb begin
        logic signed [32:0]      av;
        logic signed [32:0]      bv;
        logic signed [32:0]      cv;
        logic signed [32:0]      num;
        logic        [32:0]      nmag;
        logic        [32:0]      bmag;
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] norm;
        logic        [DW-1:0]    ud;
        logic        [DW-1:0]    un;
        logic                    fits;
        t_dvl                    l;
        for (int j = 0; j < 4; j++) begin
            l    = '0;
            av   = 33'(r3_req.a[j]);
            bv   = 33'(r3_req.b[j]);
            cv   = (j == 0) ? av : -av;
            norm = r3_dot[0];
            bmag = bv[32] ? unsigned'(-bv) : unsigned'(bv);
            v    = '0;
            num  = '0;
            ud   = '0;
            unique case (r3_req.mode)
                MD_ADD:  v = SUM_W'(av + bv);
                MD_SUB:  v = SUM_W'(av - bv);
                MD_SMUL, MD_HAM, MD_SCALE: v = r3_dot[j];
                MD_CONJ: v = SUM_W'(cv);
                MD_INV: begin
                    if (r3_req.a_zero) begin
                        v = '0;
                    end else if (norm == '0) begin
                        // tiny nonzero input: push each nonzero lane past range by sign
                        v = SUM_W'(cv) <<< 32;
                    end else begin
                        l.is_div = 1'b1;
                        num      = cv;
                        ud       = DW'(norm);
                        l.neg    = cv[32];
                    end
                end
                MD_UNSC: begin
                    if (r3_req.b_zero[j]) begin
                        v = SUM_W'(av);
                    end else begin
                        l.is_div = 1'b1;
                        num      = av;
                        ud       = DW'(bmag);
                        l.neg    = av[32] ^ bv[32];
                    end
                end
                default: v = '0;
            endcase
            nmag  = num[32] ? unsigned'(-num) : unsigned'(num);
            un    = DW'(nmag) << FRAC_BITS;
            l.r   = (un << 1) + ud;
            l.d   = ud << 1;
            fits  = (&v[SUM_W-1:31]) || !(|v[SUM_W-1:31]);
            l.res = fits ? v[31:0] : (v[SUM_W-1] ? WORD_MIN : WORD_MAX);
            l.sat = !fits;
            n_lane[j] = l;
        end
    end

    // finish divides, apply sign, saturate
    always_comb begin
        t_dvl s;
        n_out.sat = 1'b0;
        n_out.dz  = r_dv_dz[QW];
        for (int j = 0; j < 4; j++) begin
            s = r_dv[QW][j];
            n_out.r[j] = s.res;
            if (s.is_div) begin
                if (s.ovf) begin
                    n_out.r[j] = s.neg ? WORD_MIN : WORD_MAX;
                    n_out.sat  = 1'b1;
                end else if (s.neg) begin
                    if (s.q > 32'h8000_0000) begin
                        n_out.r[j] = WORD_MIN;
                        n_out.sat  = 1'b1;
                    end else begin
                        n_out.r[j] = ~s.q + 32'd1;
                    end
                end else if (s.q[31]) begin
                    n_out.r[j] = WORD_MAX;
                    n_out.sat  = 1'b1;
                end else begin
                    n_out.r[j] = s.q;
                end
            end else if (s.sat) begin
                n_out.sat = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_head_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r_out_valid <= r_dv_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_req  <= i_head;
            r1_prod <= n_prod;
            r1_neg  <= n_neg;
            r2_req  <= r1_req;
            r2_pair <= n_pair;
            r3_req  <= r2_req;
            r3_dot  <= n_dot;
            r4_lane <= n_lane;
            r4_dz   <= (r3_req.mode == MD_INV) && r3_req.a_zero;
            r_out   <= n_out;
        end
    end

    // divider entry: split numerator, catch quotients past 32 bits
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_dv0[j]     = r4_lane[j];
            n_dv0[j].r   = r4_lane[j].r >> QW;
            n_dv0[j].nlo = r4_lane[j].r[QW-1:0];
            n_dv0[j].ovf = (r4_lane[j].r >> QW) >= r4_lane[j].d;
            n_dv0[j].q   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (en) begin
            r_dv_valid[0] <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_dz[0] <= r4_dz;
            for (int j = 0; j < 4; j++) begin
                r_dv[0][j] <= n_dv0[j];
            end
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_dz[k+1] <= r_dv_dz[k];
                for (int j = 0; j < 4; j++) begin
                    r_dv[k+1][j] <= dv_step(r_dv[k][j]);
                end
            end
        end
    end

endmodule

// ===== design/quaternion_alu_top.sv =====
// Quaternion arithmetic unit, signed fixed point with FRAC_BITS fraction bits.
// Throughput: one request per cycle while the output is not held; every opcode runs through the same 32-stage
// restoring divider, one quotient bit per stage, so latency does not depend on opcode.
// Reset: synchronous, active low; clears all valid flags and queue pointers,
// payload registers keep whatever they held.
module quaternion_alu_top #(
    parameter int FRAC_BITS = qa_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [2:0]    i_mode,
    input  qa_pkg::t_word i_a_w,
    input  qa_pkg::t_word i_a_x,
    input  qa_pkg::t_word i_a_y,
    input  qa_pkg::t_word i_a_z,
    input  qa_pkg::t_word i_b_w,
    input  qa_pkg::t_word i_b_x,
    input  qa_pkg::t_word i_b_y,
    input  qa_pkg::t_word i_b_z,
    output logic          o_valid,
    input  logic          i_stall,
    output qa_pkg::t_word o_r_w,
    output qa_pkg::t_word o_r_x,
    output qa_pkg::t_word o_r_y,
    output qa_pkg::t_word o_r_z,
    output logic          o_saturated,
    output logic          o_div_zero
);
    import qa_pkg::*;

    logic push;
    logic full;
    logic head_valid;
    logic pop;
    t_req front_req;
    t_req head;
    t_res res;

    // Front: register the request, decode opcode and zero operands.
    qa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mode  (i_mode),
        .i_a_w   (i_a_w),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_a_z   (i_a_z),
        .i_b_w   (i_b_w),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_b_z   (i_b_z),
        .i_full  (full),
        .o_push  (push),
        .o_req   (front_req)
    );

    // Short queue: lets the front keep taking requests while the back is held.
    qa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_req),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head)
    );

    // Back: multiply, round, select, divide, saturate; stalls as one when
    // the output register holds an untaken result.
    qa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_res        (res)
    );

    assign o_r_w       = res.r[0];
    assign o_r_x       = res.r[1];
    assign o_r_y       = res.r[2];
    assign o_r_z       = res.r[3];
    assign o_saturated = res.sat;
    assign o_div_zero  = res.dz;

endmodule

// ===== design/qa_checker.sv =====
module qa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input logic          i_stall,
    input qa_pkg::t_word o_r_w,
    input qa_pkg::t_word o_r_x,
    input qa_pkg::t_word o_r_y,
    input qa_pkg::t_word o_r_z,
    input logic          o_saturated,
    input logic          o_div_zero
);
    import qa_pkg::*;

    // no result survives reset
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // held result does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_r_w) && $stable(o_r_x)
            && $stable(o_r_y) && $stable(o_r_z) && $stable(o_saturated)
            && $stable(o_div_zero))
        else $error("held result changed");

    // inverse of zero gives zero, unclipped
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> (o_r_w == '0) && (o_r_x == '0) && (o_r_y == '0)
            && (o_r_z == '0) && !o_saturated)
        else $error("divide by zero result not zero");

    // clipping leaves a rail value behind
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> (o_r_w == WORD_MAX) || (o_r_w == WORD_MIN)
            || (o_r_x == WORD_MAX) || (o_r_x == WORD_MIN)
            || (o_r_y == WORD_MAX) || (o_r_y == WORD_MIN)
            || (o_r_z == WORD_MAX) || (o_r_z == WORD_MIN))
        else $error("saturated without a clipped component");

endmodule

bind quaternion_alu_top qa_checker u_qa_checker (.*);
